// ===== sv/qcm_pkg.sv =====
package qcm_pkg;

   localparam int CHANNELS_DEFAULT = 512;

   localparam int SAMPLE_W    = 8;
   localparam int CHAN_W      = 9;
   localparam int SUM_W       = 32;
   localparam int MULT_W      = 31;
   localparam int SHIFT_W     = 6;
   localparam int ZP_W        = 8;
   localparam int COUNT_W     = 17;
   localparam int MODE_W      = 2;
   localparam int MEAN_W      = 8;
   localparam int RIGHT_W     = 5;
   localparam int CORR_W      = ZP_W + COUNT_W + 1;
   localparam int PROD_W      = 2 * SUM_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [MULT_W-1:0]         MULTIPLIER_RESET   = MULT_W'(1073741824);
   localparam logic signed [SHIFT_W-1:0] SHIFT_RESET        = '0;
   localparam logic signed [ZP_W-1:0]    ZERO_POINT_RESET   = '0;
   localparam logic [COUNT_W-1:0]        COUNT_RESET        = COUNT_W'(196);

   localparam logic [RIGHT_W-1:0]      RIGHT_MAX = '1;
   localparam logic signed [SUM_W-1:0] MEAN_MAX  = 32'sd127;
   localparam logic signed [SUM_W-1:0] MEAN_MIN  = -32'sd128;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MULTIPLIER        = 3'd0,
      CSR_SHIFT_AMOUNT      = 3'd1,
      CSR_INPUT_ZERO_POINT  = 3'd2,
      CSR_OUTPUT_ZERO_POINT = 3'd3,
      CSR_ELEMENT_COUNT     = 3'd4,
      CSR_ROUNDING_MODE     = 3'd5
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      ROUND_AWAY = 2'd0,
      ROUND_HALF = 2'd1,
      ROUND_GE   = 2'd2
   } rounding_mode_type;

   localparam logic [MODE_W-1:0] ROUNDING_RESET = ROUND_AWAY;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [SUM_W-1:0]  sum;
   } sum_item_type;

   typedef struct packed {
      logic [MULT_W-1:0]  multiplier;
      logic [SHIFT_W-1:0] shift_amount;
      logic [ZP_W-1:0]    output_zero_point;
      logic [MODE_W-1:0]  rounding_mode;
      logic [CORR_W-1:0]  zero_correction;
   } requant_cfg_type;

endpackage

// ===== sv/quantized_int8_channel_mean.sv =====
// Per-channel int8 mean with fixed-point requantization.
// Input transactions (req_) carry a sample, a channel and first/last flags. A first
// sample starts the channel's 32-bit sum; later samples add to it. A transaction
// with last set produces one output transaction (rsp_) with the channel and the
// requantized, clipped int8 mean. Channels at or above CHANNELS are dropped.
// One input transaction is accepted per cycle while req_stall is low. The sums live
// in a single dual-port RAM with a registered read port; back-to-back updates of
// one channel are forwarded around the write-back, so any channel order streams at
// full rate. After its last sample is accepted, a result passes the s1 register
// and then the requantization pipeline (one 32x32 multiply, a 64-bit rounding add
// and the rounding shift, each in its own stage).
// When rsp_stall is high the output holds and the pipeline fills; req_stall rises
// only when a transaction with last set cannot move on.
// Reset empties the pipeline and loads the register defaults; channel sums are
// undefined until a first sample writes them. Registers are written through
// csr_ (always ready) and may only change while no transaction is in flight.
module quantized_int8_channel_mean #(
   parameter int CHANNELS = qcm_pkg::CHANNELS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [qcm_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic [qcm_pkg::CHAN_W-1:0]            req_channel,
   input  logic                                   req_first,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [qcm_pkg::CHAN_W-1:0]            rsp_out_channel,
   output logic signed [qcm_pkg::MEAN_W-1:0]     rsp_mean_value,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [qcm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [qcm_pkg::CSR_DATA_W-1:0]        csr_data
);

   logic [qcm_pkg::MULT_W-1:0]         multiplier_ff;
   logic signed [qcm_pkg::SHIFT_W-1:0] shift_ff;
   logic signed [qcm_pkg::ZP_W-1:0]    in_zp_ff;
   logic signed [qcm_pkg::ZP_W-1:0]    out_zp_ff;
   logic [qcm_pkg::COUNT_W-1:0]        count_ff;
   logic [qcm_pkg::MODE_W-1:0]         mode_ff;
   logic signed [qcm_pkg::CORR_W-1:0]  corr_ff, corr_in;

   qcm_pkg::requant_cfg_type cfg;
   qcm_pkg::sum_item_type    sum_item;
   logic                     sum_valid;
   logic                     sum_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         multiplier_ff <= qcm_pkg::MULTIPLIER_RESET;
         shift_ff      <= qcm_pkg::SHIFT_RESET;
         in_zp_ff      <= qcm_pkg::ZERO_POINT_RESET;
         out_zp_ff     <= qcm_pkg::ZERO_POINT_RESET;
         count_ff      <= qcm_pkg::COUNT_RESET;
         mode_ff       <= qcm_pkg::ROUNDING_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            qcm_pkg::CSR_MULTIPLIER:        multiplier_ff <= csr_data[qcm_pkg::MULT_W-1:0];
            qcm_pkg::CSR_SHIFT_AMOUNT:      shift_ff      <= csr_data[qcm_pkg::SHIFT_W-1:0];
            qcm_pkg::CSR_INPUT_ZERO_POINT:  in_zp_ff      <= csr_data[qcm_pkg::ZP_W-1:0];
            qcm_pkg::CSR_OUTPUT_ZERO_POINT: out_zp_ff     <= csr_data[qcm_pkg::ZP_W-1:0];
            qcm_pkg::CSR_ELEMENT_COUNT:     count_ff      <= csr_data[qcm_pkg::COUNT_W-1:0];
            qcm_pkg::CSR_ROUNDING_MODE:     mode_ff       <= csr_data[qcm_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // The zero-point correction only follows register writes, so it is kept registered.
   assign corr_in =
      $signed({{(qcm_pkg::CORR_W - qcm_pkg::ZP_W){in_zp_ff[qcm_pkg::ZP_W-1]}}, in_zp_ff}) *
      $signed({{(qcm_pkg::CORR_W - qcm_pkg::COUNT_W){1'b0}}, count_ff});

   always_ff @(posedge clock) begin
      corr_ff <= corr_in;
   end

   assign cfg.multiplier        = multiplier_ff;
   assign cfg.shift_amount      = shift_ff;
   assign cfg.output_zero_point = out_zp_ff;
   assign cfg.rounding_mode     = mode_ff;
   assign cfg.zero_correction   = corr_ff;

   qcm_accum #(
      .CHANNELS (CHANNELS)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .req_channel (req_channel),
      .req_first   (req_first),
      .req_last    (req_last),
      .sum_valid   (sum_valid),
      .sum_item    (sum_item),
      .sum_ready   (sum_ready)
   );

   qcm_requant u_requant (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (sum_valid),
      .in_item         (sum_item),
      .in_ready        (sum_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_mean_value  (rsp_mean_value)
   );

endmodule

// ===== sv/qcm_ram.sv =====
module qcm_ram #(
   parameter int WIDTH = qcm_pkg::SUM_W,
   parameter int DEPTH = qcm_pkg::CHANNELS_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/qcm_accum.sv =====
module qcm_accum #(
   parameter int CHANNELS = qcm_pkg::CHANNELS_DEFAULT,
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [qcm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [qcm_pkg::CHAN_W-1:0]          req_channel,
   input  logic                                 req_first,
   input  logic                                 req_last,
   output logic                                 sum_valid,
   output qcm_pkg::sum_item_type                sum_item,
   input  logic                                 sum_ready
);

   localparam int EXT_W = ADDR_W + qcm_pkg::CHAN_W;

   logic [EXT_W-1:0]  channel_ext;
   logic [ADDR_W-1:0] addr;
   logic              in_range;
   logic              accept;
   logic              s1_go;

   logic                                 s1_valid_ff, s1_valid_in;
   logic                                 s1_fwd_ff, s1_fwd_in;
   logic signed [qcm_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic [qcm_pkg::CHAN_W-1:0]          s1_channel_ff;
   logic [ADDR_W-1:0]                   s1_addr_ff;
   logic                                 s1_first_ff;
   logic                                 s1_last_ff;
   logic [qcm_pkg::SUM_W-1:0]           wr_data_ff;

   logic [qcm_pkg::SUM_W-1:0] rd_data;
   logic [qcm_pkg::SUM_W-1:0] base;
   logic [qcm_pkg::SUM_W-1:0] sample_ext;
   logic [qcm_pkg::SUM_W-1:0] sum;

   assign channel_ext = EXT_W'(req_channel);
   assign addr        = channel_ext[ADDR_W-1:0];
   assign in_range    = 32'(req_channel) < 32'(CHANNELS);

   assign s1_go     = s1_valid_ff && (!s1_last_ff || sum_ready);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_fwd_in   = s1_fwd_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid && in_range;
         s1_fwd_in   = s1_go && (s1_addr_ff == addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_fwd_ff <= s1_fwd_in;
      if (accept) begin
         s1_sample_ff  <= req_sample;
         s1_channel_ff <= req_channel;
         s1_addr_ff    <= addr;
         s1_first_ff   <= req_first;
         s1_last_ff    <= req_last;
      end
      if (s1_go) begin
         wr_data_ff <= sum;
      end
   end

   // A transaction read its sum in the same cycle that the one ahead wrote it back.
   assign base       = s1_fwd_ff ? wr_data_ff : rd_data;
   assign sample_ext = {{(qcm_pkg::SUM_W - qcm_pkg::SAMPLE_W){s1_sample_ff[qcm_pkg::SAMPLE_W-1]}},
                        s1_sample_ff};
   assign sum        = s1_first_ff ? sample_ext : base + sample_ext;

   qcm_ram #(
      .WIDTH (qcm_pkg::SUM_W),
      .DEPTH (CHANNELS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data (sum),
      .rd_en   (accept && in_range),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   assign sum_valid        = s1_valid_ff && s1_last_ff;
   assign sum_item.channel = s1_channel_ff;
   assign sum_item.sum     = sum;

endmodule

// ===== sv/qcm_requant.sv =====
module qcm_requant (
   input  logic                                clock,
   input  logic                                reset,
   input  qcm_pkg::requant_cfg_type            cfg,
   input  logic                                in_valid,
   input  qcm_pkg::sum_item_type               in_item,
   output logic                                in_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [qcm_pkg::CHAN_W-1:0]         rsp_out_channel,
   output logic signed [qcm_pkg::MEAN_W-1:0] rsp_mean_value
);

   localparam int STAGES = 7;
   localparam int SUM_W  = qcm_pkg::SUM_W;
   localparam int PROD_W = qcm_pkg::PROD_W;
   localparam logic signed [PROD_W-1:0] NUDGE_POS = 64'sd1 <<< 30;
   localparam logic signed [PROD_W-1:0] NUDGE_NEG = 64'sd1 - NUDGE_POS;

   logic [STAGES:1] valid_ff, valid_in, stage_en;
   logic [qcm_pkg::CHAN_W-1:0] channel_ff [1:STAGES];

   logic                          shift_neg;
   logic [qcm_pkg::SHIFT_W-1:0]   shift_mag;
   logic [qcm_pkg::RIGHT_W-1:0]   left_amt;
   logic [qcm_pkg::RIGHT_W-1:0]   right_amt;
   logic                          mode_ge;
   logic                          mode_bias;
   logic [SUM_W-1:0]              correction;
   logic [SUM_W-1:0]              out_zp;
   logic [SUM_W-1:0]              mask;

   logic signed [SUM_W-1:0]  x_ff, x_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] t_ff, t_in;
   logic signed [SUM_W-1:0]  y_ff, y_in;
   logic signed [SUM_W-1:0]  shifted_ff, shifted_in;
   logic [SUM_W-1:0]         rem_ff, rem_in;
   logic [SUM_W-1:0]         thr_ff, thr_in;
   logic                     shift_nz_ff, shift_nz_in;
   logic signed [SUM_W-1:0]  z_ff, z_in;
   logic                     round_up;
   logic signed [SUM_W-1:0]  v;
   logic signed [qcm_pkg::MEAN_W-1:0] mean_ff, mean_in;

   always_comb begin
      stage_en[STAGES] = !valid_ff[STAGES] || !rsp_stall;
      for (int k = STAGES - 1; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[1] = stage_en[1] ? in_valid : valid_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         channel_ff[1] <= in_item.channel;
      end
      for (int k = 2; k <= STAGES; k++) begin
         if (stage_en[k]) begin
            channel_ff[k] <= channel_ff[k-1];
         end
      end
   end

   assign shift_neg = cfg.shift_amount[qcm_pkg::SHIFT_W-1];
   assign shift_mag = -cfg.shift_amount;
   assign left_amt  = shift_neg ? '0 : cfg.shift_amount[qcm_pkg::RIGHT_W-1:0];
   assign right_amt = !shift_neg ? '0 :
                      (shift_mag[qcm_pkg::SHIFT_W-1] ? qcm_pkg::RIGHT_MAX
                                                     : shift_mag[qcm_pkg::RIGHT_W-1:0]);
   assign mode_ge   = (cfg.rounding_mode != qcm_pkg::ROUND_AWAY) &&
                      (cfg.rounding_mode != qcm_pkg::ROUND_HALF);
   assign mode_bias = cfg.rounding_mode != qcm_pkg::ROUND_HALF;
   assign correction = {{(SUM_W - qcm_pkg::CORR_W){cfg.zero_correction[qcm_pkg::CORR_W-1]}},
                        cfg.zero_correction};
   assign out_zp     = {{(SUM_W - qcm_pkg::ZP_W){cfg.output_zero_point[qcm_pkg::ZP_W-1]}},
                        cfg.output_zero_point};

   assign x_in    = (in_item.sum - correction) << left_amt;
   assign prod_in = PROD_W'(x_ff) * PROD_W'($signed({1'b0, cfg.multiplier}));
   assign t_in    = prod_ff + (prod_ff[PROD_W-1] ? NUDGE_NEG : NUDGE_POS);

   // Truncate toward zero: negative values with a nonzero fraction move up by one.
   assign y_in = t_ff[PROD_W-2:SUM_W-1] +
                 SUM_W'(t_ff[PROD_W-1] && (t_ff[SUM_W-2:0] != '0));

   assign mask        = ~({SUM_W{1'b1}} << right_amt);
   assign shifted_in  = y_ff >>> right_amt;
   assign rem_in      = y_ff & mask;
   assign thr_in      = (mask >> 1) + SUM_W'(mode_bias && y_ff[SUM_W-1]);
   assign shift_nz_in = right_amt != '0;

   assign round_up = shift_nz_ff && (mode_ge ? (rem_ff >= thr_ff) : (rem_ff > thr_ff));
   assign z_in     = shifted_ff + SUM_W'(round_up);

   assign v = z_ff + out_zp;

   always_comb begin
      if (v > qcm_pkg::MEAN_MAX) begin
         mean_in = qcm_pkg::MEAN_MAX[qcm_pkg::MEAN_W-1:0];
      end else if (v < qcm_pkg::MEAN_MIN) begin
         mean_in = qcm_pkg::MEAN_MIN[qcm_pkg::MEAN_W-1:0];
      end else begin
         mean_in = v[qcm_pkg::MEAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         x_ff <= x_in;
      end
      if (stage_en[2]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[3]) begin
         t_ff <= t_in;
      end
      if (stage_en[4]) begin
         y_ff <= y_in;
      end
      if (stage_en[5]) begin
         shifted_ff  <= shifted_in;
         rem_ff      <= rem_in;
         thr_ff      <= thr_in;
         shift_nz_ff <= shift_nz_in;
      end
      if (stage_en[6]) begin
         z_ff <= z_in;
      end
      if (stage_en[7]) begin
         mean_ff <= mean_in;
      end
   end

   assign in_ready        = stage_en[1];
   assign rsp_valid       = valid_ff[STAGES];
   assign rsp_out_channel = channel_ff[STAGES];
   assign rsp_mean_value  = mean_ff;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import qcm_pkg::*;

   localparam int CHANNELS = CHANNELS_DEFAULT;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 238;
   localparam int DRAIN_CYCLES = 12;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_PRINTED = 40;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam logic [MODE_W-1:0] ROUND_SPARE = 2'd3;
   localparam logic [MULT_W-1:0] MULT_MAX = 31'h7FFF_FFFF;
   localparam logic [MULT_W-1:0] MULT_ZERO = 31'd0;
   localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = 6'sh20;
   localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = 6'sh1F;
   localparam logic signed [SHIFT_W-1:0] SHIFT_HALF = -6'sd1;
   localparam logic signed [ZP_W-1:0] ZP_MIN = -8'sd128;
   localparam logic signed [ZP_W-1:0] ZP_MAX = 8'sd127;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_ZERO = 17'd0;
   localparam longint HALF_Q31 = 64'sd1073741824;
   localparam longint ONE_Q31 = 64'sd2147483648;

   typedef struct {
      logic [CHAN_W-1:0] channel;
      logic [MEAN_W-1:0] mean;
   } mean_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic [CHAN_W-1:0] req_channel;
   logic req_first;
   logic req_last;
   logic rsp_valid;
   logic rsp_stall;
   logic [CHAN_W-1:0] rsp_out_channel;
   logic signed [MEAN_W-1:0] rsp_mean_value;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   logic [MULT_W-1:0] cfg_multiplier;
   logic signed [SHIFT_W-1:0] cfg_shift;
   logic signed [ZP_W-1:0] cfg_in_zp;
   logic signed [ZP_W-1:0] cfg_out_zp;
   logic [COUNT_W-1:0] cfg_count;
   logic [MODE_W-1:0] cfg_mode;

   logic [SUM_W-1:0] sum_store [CHANNELS];
   bit sum_written [CHANNELS];
   mean_result_type mean_queue [$];

   bit quiet;
   int mismatch_count;
   int sent_count;
   int checked_count;
   int settings_count;

   quantized_int8_channel_mean #(
      .CHANNELS(CHANNELS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .req_channel(req_channel),
      .req_first(req_first),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_channel(rsp_out_channel),
      .rsp_mean_value(rsp_mean_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("tb_top: mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   function automatic logic [MEAN_W-1:0] requantize_mean(logic [SUM_W-1:0] total);
      logic [SUM_W-1:0] corr;
      logic [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] z;
      logic signed [SUM_W-1:0] v;
      logic [SUM_W-1:0] mask;
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] thr;
      longint prod;
      longint nudge;
      longint quot;
      int left;
      int right;
      bit up;
      corr = {{24{cfg_in_zp[7]}}, cfg_in_zp} * {15'd0, cfg_count};
      x = total - corr;
      left = (cfg_shift > 0) ? int'(cfg_shift) : 0;
      right = (cfg_shift < 0) ? -int'(cfg_shift) : 0;
      if (right > 31) begin
         right = 31;
      end
      x = x << left;
      prod = longint'($signed(x)) * longint'({33'd0, cfg_multiplier});
      nudge = (prod >= 0) ? HALF_Q31 : (64'sd1 - HALF_Q31);
      quot = (prod + nudge) / ONE_Q31;
      y = quot[31:0];
      if (right == 0) begin
         z = y;
      end else begin
         mask = 32'hFFFF_FFFF >> (32 - right);
         rem = y & mask;
         thr = (mask >> 1) + ((cfg_mode != ROUND_HALF && y < 0) ? 32'd1 : 32'd0);
         up = (cfg_mode >= ROUND_GE) ? (rem >= thr) : (rem > thr);
         z = (y >>> right) + (up ? 32'sd1 : 32'sd0);
      end
      v = z + $signed({{24{cfg_out_zp[7]}}, cfg_out_zp});
      if (v > MEAN_MAX) begin
         v = MEAN_MAX;
      end
      if (v < MEAN_MIN) begin
         v = MEAN_MIN;
      end
      return v[MEAN_W-1:0];
   endfunction

   function automatic void accumulate_sample(logic signed [SAMPLE_W-1:0] smp,
                                             logic [CHAN_W-1:0] ch, bit is_first,
                                             bit is_last);
      logic [SUM_W-1:0] total;
      mean_result_type res;
      if (ch >= CHANNELS) begin
         return;
      end
      total = is_first ? {{24{smp[7]}}, smp} : sum_store[ch] + {{24{smp[7]}}, smp};
      sum_store[ch] = total;
      if (is_first) begin
         sum_written[ch] = 1'b1;
      end
      if (is_last) begin
         res.channel = ch;
         res.mean = requantize_mean(total);
         mean_queue.push_back(res);
      end
   endfunction

   task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, logic [CHAN_W-1:0] ch,
                              bit is_first, bit is_last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         if (req_valid) begin
            req_valid <= 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= smp;
      req_channel <= ch;
      req_first <= is_first;
      req_last <= is_last;
      do @(posedge clock); while (req_stall);
      accumulate_sample(smp, ch, is_first, is_last);
      sent_count++;
   endtask

   task automatic wait_drained();
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      while (mean_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MULTIPLIER: cfg_multiplier = data[MULT_W-1:0];
         CSR_SHIFT_AMOUNT: cfg_shift = data[SHIFT_W-1:0];
         CSR_INPUT_ZERO_POINT: cfg_in_zp = data[ZP_W-1:0];
         CSR_OUTPUT_ZERO_POINT: cfg_out_zp = data[ZP_W-1:0];
         CSR_ELEMENT_COUNT: cfg_count = data[COUNT_W-1:0];
         CSR_ROUNDING_MODE: cfg_mode = data[MODE_W-1:0];
         default: ;
      endcase
   endtask

   // Unused upper bits of each write carry random junk.
   task automatic program_settings(logic [MULT_W-1:0] mult, logic signed [SHIFT_W-1:0] shift,
                                   logic signed [ZP_W-1:0] in_zp,
                                   logic signed [ZP_W-1:0] out_zp,
                                   logic [COUNT_W-1:0] count, logic [MODE_W-1:0] mode);
      logic [31:0] junk;
      wait_drained();
      junk = $urandom();
      write_register(CSR_MULTIPLIER, {junk[31], mult});
      junk = $urandom();
      write_register(CSR_SHIFT_AMOUNT, {junk[31:6], shift});
      junk = $urandom();
      write_register(CSR_INPUT_ZERO_POINT, {junk[31:8], in_zp});
      junk = $urandom();
      write_register(CSR_OUTPUT_ZERO_POINT, {junk[31:8], out_zp});
      junk = $urandom();
      write_register(CSR_ELEMENT_COUNT, {junk[31:17], count});
      junk = $urandom();
      write_register(CSR_ROUNDING_MODE, {junk[31:2], mode});
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   task automatic test_default_settings();
      send_sample(8'sd127, 9'd0, 1'b1, 1'b1);
      send_sample(-8'sd128, 9'd511, 1'b1, 1'b1);
      send_sample(8'sd0, 9'd256, 1'b1, 1'b1);
   endtask

   task automatic test_accumulate_and_restart();
      send_sample(8'sd100, 9'd5, 1'b1, 1'b0);
      send_sample(8'sd100, 9'd5, 1'b0, 1'b0);
      send_sample(8'sd100, 9'd5, 1'b0, 1'b1);
      send_sample(-8'sd3, 9'd5, 1'b1, 1'b1);
      send_sample(-8'sd128, 9'd6, 1'b1, 1'b0);
      send_sample(-8'sd128, 9'd6, 1'b0, 1'b1);
   endtask

   task automatic test_back_to_back_channels();
      quiet = 1'b1;
      send_sample(8'sd1, 9'd7, 1'b1, 1'b0);
      send_sample(8'sd2, 9'd7, 1'b0, 1'b0);
      send_sample(-8'sd5, 9'd8, 1'b1, 1'b1);
      send_sample(8'sd3, 9'd7, 1'b0, 1'b0);
      send_sample(8'sd4, 9'd7, 1'b0, 1'b1);
      quiet = 1'b0;
   endtask

   task automatic test_rounding_modes();
      logic [MODE_W-1:0] modes [4];
      modes = '{ROUND_AWAY, ROUND_HALF, ROUND_GE, ROUND_SPARE};
      for (int m = 0; m < 4; m++) begin
         program_settings(MULT_MAX, SHIFT_HALF, 8'sd0, 8'sd0, COUNT_RESET, modes[m]);
         send_sample(8'sd3, 9'(20 + m), 1'b1, 1'b1);
         send_sample(-8'sd3, 9'(24 + m), 1'b1, 1'b1);
      end
   endtask

   task automatic test_shift_and_zero_point_extremes();
      program_settings(MULT_MAX, SHIFT_MIN, 8'sd0, 8'sd0, 17'd1, ROUND_GE);
      send_sample(8'sd127, 9'd30, 1'b1, 1'b1);
      program_settings(MULTIPLIER_RESET, SHIFT_MAX, 8'sd0, -8'sd3, 17'd1, ROUND_AWAY);
      send_sample(8'sd1, 9'd31, 1'b1, 1'b1);
      program_settings(31'h0100_0000, 6'sd0, ZP_MIN, ZP_MAX, COUNT_MAX, ROUND_HALF);
      send_sample(-8'sd128, 9'd32, 1'b1, 1'b1);
      wait_drained();
      write_register(CSR_SPARE_A, $urandom());
      write_register(CSR_SPARE_B, $urandom());
      csr_valid <= 1'b0;
      send_sample(8'sd50, 9'd33, 1'b1, 1'b1);
   endtask

   task automatic random_settings(int style);
      logic [MULT_W-1:0] mult;
      logic signed [SHIFT_W-1:0] shift;
      logic signed [ZP_W-1:0] in_zp;
      logic signed [ZP_W-1:0] out_zp;
      logic [COUNT_W-1:0] count;
      logic [MODE_W-1:0] mode;
      int pick;
      case (style)
         1: program_settings(MULT_MAX, SHIFT_MAX, ZP_MAX, ZP_MAX, COUNT_MAX, ROUND_SPARE);
         2: program_settings(MULT_ZERO, SHIFT_MIN, ZP_MIN, ZP_MIN, COUNT_ZERO, ROUND_AWAY);
         3: begin
            mult = MULT_W'($urandom());
            shift = SHIFT_W'($urandom());
            in_zp = ZP_W'($urandom());
            out_zp = ZP_W'($urandom());
            count = COUNT_W'($urandom());
            mode = MODE_W'($urandom());
            program_settings(mult, shift, in_zp, out_zp, count, mode);
         end
         default: begin
            mult = MULT_W'($urandom_range(32'h2000_0000, 32'h7FFF_FFFF));
            pick = int'($urandom_range(0, 6)) - 4;
            shift = pick[SHIFT_W-1:0];
            pick = int'($urandom_range(0, 16)) - 8;
            in_zp = pick[ZP_W-1:0];
            out_zp = ZP_W'($urandom());
            count = COUNT_W'($urandom_range(1, 8));
            mode = MODE_W'($urandom_range(0, 3));
            program_settings(mult, shift, in_zp, out_zp, count, mode);
         end
      endcase
   endtask

   // Mostly well-formed first/add/last sequences over interleaved channels,
   // with a quarter of the transactions as unordered noise on started sums.
   task automatic run_random_phase(int n_items);
      int open_ch [$];
      int k;
      int r;
      int ch;
      bit fl;
      bit ll;
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 2) begin
            wait_drained();
         end
         r = $urandom_range(0, 99);
         if (r < 75 && (open_ch.size() == 0 || (open_ch.size() < 6 && r < 20))) begin
            ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                               : $urandom_range(0, CHANNELS - 1);
            ll = ($urandom_range(0, 7) == 0);
            send_sample(SAMPLE_W'($urandom()), CHAN_W'(ch), 1'b1, ll);
            if (!ll) begin
               open_ch.push_back(ch);
            end
         end else if (r < 75) begin
            k = ($urandom_range(0, 1) == 0) ? open_ch.size() - 1
                                             : $urandom_range(0, open_ch.size() - 1);
            ch = open_ch[k];
            ll = ($urandom_range(0, 3) == 0);
            send_sample(SAMPLE_W'($urandom()), CHAN_W'(ch), 1'b0, ll);
            if (ll) begin
               open_ch.delete(k);
            end
         end else begin
            ch = $urandom_range(0, CHANNELS - 1);
            fl = !sum_written[ch] || ($urandom_range(0, 1) == 1);
            ll = 1'($urandom_range(0, 1));
            send_sample(SAMPLE_W'($urandom()), CHAN_W'(ch), fl, ll);
         end
      end
   endtask

   task automatic test_random_phases();
      int style;
      for (int p = 0; p < PHASES; p++) begin
         style = (p == 1) ? 1 : (p == 2) ? 2 : (p == 5 || p == 7) ? 3 : 0;
         random_settings(style);
         quiet = (p == 3 || p == 6);
         run_random_phase(PHASE_ITEMS);
         quiet = 1'b0;
      end
   endtask

   task automatic finish_run();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb_top: %0d samples sent, %0d channel means checked, %0d register settings",
               sent_count, checked_count, settings_count);
      $display("tb_top: covered all rounding modes, shift and zero-point extremes, %s",
               "interleaved channel sums and random stalls on both sides");
      if (mismatch_count == 0 && mean_queue.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   endtask

   initial begin : response_pacing
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   always @(posedge clock) begin : check_means
      mean_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mean_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected mean %0d for channel %0d",
                                      rsp_mean_value, rsp_out_channel));
         end else begin
            want = mean_queue.pop_front();
            if (rsp_out_channel !== want.channel) begin
               report_mismatch($sformatf("channel got %0d want %0d",
                                         rsp_out_channel, want.channel));
            end
            if (rsp_mean_value !== want.mean) begin
               report_mismatch($sformatf("mean of channel %0d got %0d want %0d",
                                         want.channel, rsp_mean_value,
                                         $signed(want.mean)));
            end
            checked_count++;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample <= '0;
      req_channel <= '0;
      req_first <= 1'b0;
      req_last <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_MULTIPLIER;
      csr_data <= '0;
      quiet = 1'b0;
      mismatch_count = 0;
      sent_count = 0;
      checked_count = 0;
      settings_count = 0;
      cfg_multiplier = MULTIPLIER_RESET;
      cfg_shift = SHIFT_RESET;
      cfg_in_zp = ZERO_POINT_RESET;
      cfg_out_zp = ZERO_POINT_RESET;
      cfg_count = COUNT_RESET;
      cfg_mode = ROUNDING_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
         sum_store[c] = '0;
         sum_written[c] = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_default_settings();
      test_accumulate_and_restart();
      test_back_to_back_channels();
      test_rounding_modes();
      test_shift_and_zero_point_extremes();
      test_random_phases();
      finish_run();
   end

endmodule
